@@ rtl/core/plst_pkg.sv @@
package plst_pkg;

  // List geometry.
  localparam int unsigned DEPTH   = 128;
  localparam int unsigned ID_BITS = 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response transactions.
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned STAT_W = 3;

  // Width for comparing a request position against the count.
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Find-first search is split into groups resolved in a registered first level.
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_W    = $clog2(GRP_SIZE);
  localparam int unsigned GRP_CNT  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GSEL_W   = (GRP_CNT > 1) ? $clog2(GRP_CNT) : 1;
  localparam int unsigned PAD_W    = GRP_CNT * GRP_SIZE;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND   = 3'd0,
    REQ_INSERT   = 3'd1,
    REQ_DEL_POS  = 3'd2,
    REQ_DEL_ID   = 3'd3,
    REQ_SEARCH   = 3'd4
  } plst_req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } plst_status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } plst_cmd_e;

  typedef struct packed {
    plst_cmd_e          op;
    logic [IDX_W-1:0]   idx;
    logic [ID_BITS-1:0] id;
    logic               match_en;
    logic [CNT_W-1:0]   count;
  } plst_cell_ctl_t;

endpackage

@@ rtl/core/plst_req_if.sv @@
interface plst_req_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::REQ_W-1:0]   req_type;
  logic [plst_pkg::ID_BITS-1:0] item_id;
  logic [plst_pkg::POS_W-1:0]   position;

  modport source (output valid, output req_type, output item_id, output position,
                  input ready);
  modport sink (input valid, input req_type, input item_id, input position,
                output ready);
endinterface

@@ rtl/core/plst_rsp_if.sv @@
interface plst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [plst_pkg::STAT_W-1:0]  status;
  logic [plst_pkg::POS_W-1:0]   found_position;
  logic [plst_pkg::POS_W-1:0]   entry_count;
  logic [plst_pkg::ID_BITS-1:0] first_entry;
  logic [plst_pkg::ID_BITS-1:0] last_entry;

  modport source (output valid, output status, output found_position,
                  output entry_count, output first_entry, output last_entry,
                  input ready);
  modport sink (input valid, input status, input found_position,
                input entry_count, input first_entry, input last_entry,
                output ready);
endinterface

@@ rtl/core/plst_cell.sv @@
module plst_cell (
  input  logic                             clk_i,
  input  plst_pkg::plst_cell_ctl_t         ctl_i,
  input  logic [plst_pkg::IDX_W-1:0]       index_i,
  input  logic [plst_pkg::ID_BITS-1:0]     left_i,
  input  logic [plst_pkg::ID_BITS-1:0]     right_i,
  output logic [plst_pkg::ID_BITS-1:0]     data_o,
  output logic                             match_o,
  output logic [plst_pkg::ID_BITS-1:0]     tail_data_o
);

  logic [plst_pkg::ID_BITS-1:0] data_q, data_d;
  logic                         match_q;
  logic                         occupied;
  logic                         is_tail;

  // A cell holds a live entry when its index lies below the count.
  assign occupied = plst_pkg::CNT_W'(index_i) < ctl_i.count;
  assign is_tail  = (plst_pkg::CNT_W'(index_i) + plst_pkg::CNT_W'(1)) == ctl_i.count;

  // Insert pulls from the left neighbor above the slot, remove pulls from the right.
  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      plst_pkg::CMD_INSERT: begin
        if (index_i > ctl_i.idx) begin
          data_d = left_i;
        end else if (index_i == ctl_i.idx) begin
          data_d = ctl_i.id;
        end
      end
      plst_pkg::CMD_REMOVE: begin
        if (index_i >= ctl_i.idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctl_i.match_en) begin
      match_q <= occupied && (data_q == ctl_i.id);
    end
  end

  assign data_o      = data_q;
  assign match_o     = match_q;
  assign tail_data_o = is_tail ? data_q : '0;

endmodule

@@ rtl/core/plst_find.sv @@
module plst_find (
  input  logic                          clk_i,
  input  logic [plst_pkg::DEPTH-1:0]    match_i,
  output logic                          hit_o,
  output logic [plst_pkg::IDX_W-1:0]    index_o
);

  logic [plst_pkg::PAD_W-1:0]    match_pad;
  logic                          grp_hit_d [plst_pkg::GRP_CNT];
  logic [plst_pkg::GRP_W-1:0]    grp_idx_d [plst_pkg::GRP_CNT];
  logic                          grp_hit_q [plst_pkg::GRP_CNT];
  logic [plst_pkg::GRP_W-1:0]    grp_idx_q [plst_pkg::GRP_CNT];
  logic [plst_pkg::GSEL_W-1:0]   sel;

  assign match_pad = plst_pkg::PAD_W'(match_i);

  // First level: lowest set bit within each group.
  always_comb begin
    for (int g = 0; g < plst_pkg::GRP_CNT; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int j = plst_pkg::GRP_SIZE - 1; j >= 0; j--) begin
        if (match_pad[g * plst_pkg::GRP_SIZE + j]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = plst_pkg::GRP_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < plst_pkg::GRP_CNT; g++) begin
      grp_hit_q[g] <= grp_hit_d[g];
      grp_idx_q[g] <= grp_idx_d[g];
    end
  end

  // Second level: lowest group that holds a match.
  always_comb begin
    hit_o = 1'b0;
    sel   = '0;
    for (int g = plst_pkg::GRP_CNT - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit_o = 1'b1;
        sel   = plst_pkg::GSEL_W'(g);
      end
    end
  end

  assign index_o = plst_pkg::IDX_W'({sel, grp_idx_q[sel]});

endmodule

@@ rtl/core/positional_list_store_top.sv @@
// Positional list store: an ordered list of up to DEPTH identifiers kept packed
// from position 1, held in a chain of cells that shift toward their neighbors.
// Requests arrive on req_i (append, insert at position, delete at position,
// delete by id, search) and each one produces exactly one response transaction
// on rsp_o with status, found position, count and the first and last entries.
// The block works on one request at a time and takes no new request until
// the previous one has been written to the response register. A request
// passes through the search, apply and report stages: every cell compares on
// accept, the lowest match is resolved through a registered two-level group
// encoder, the cells shift in the apply stage and the new tail entry is read
// out in the report stage.
// The response sits in an output register; req_i is ready again while it waits.
// If the receiver stalls, a following request is still processed up to the
// response stage and then holds there until the waiting response is taken.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending
// response. Cell contents are not cleared; only cells below the count are read.
module positional_list_store_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  plst_req_if.sink     req_i,
  plst_rsp_if.source   rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_APPLY,
    ST_REPORT
  } state_e;

  state_e                            state_q;
  logic [plst_pkg::CNT_W-1:0]        count_q, count_d;
  logic [plst_pkg::REQ_W-1:0]        req_q;
  logic [plst_pkg::ID_BITS-1:0]      id_q;
  logic [plst_pkg::POS_W-1:0]        pos_q;
  plst_pkg::plst_status_e            status_q, status_d;
  logic [plst_pkg::CNT_W-1:0]        found_q, found_d;
  logic                              rsp_valid_q;
  logic [plst_pkg::STAT_W-1:0]       rsp_status_q;
  logic [plst_pkg::POS_W-1:0]        rsp_found_q;
  logic [plst_pkg::POS_W-1:0]        rsp_count_q;
  logic [plst_pkg::ID_BITS-1:0]      rsp_first_q;
  logic [plst_pkg::ID_BITS-1:0]      rsp_last_q;

  logic                              accept;
  logic                              rsp_free;
  plst_pkg::plst_cell_ctl_t          cell_ctl;
  plst_pkg::plst_cmd_e               apply_op;
  logic [plst_pkg::IDX_W-1:0]        apply_idx;
  logic [plst_pkg::ID_BITS-1:0]      cell_data [plst_pkg::DEPTH];
  logic [plst_pkg::ID_BITS-1:0]      tail_data [plst_pkg::DEPTH];
  logic [plst_pkg::DEPTH-1:0]        match;
  logic [plst_pkg::ID_BITS-1:0]      tail_or;
  logic                              hit;
  logic [plst_pkg::IDX_W-1:0]        hit_idx;
  logic                              full;
  logic                              empty;
  logic                              ins_bad;
  logic                              del_bad;
  logic [plst_pkg::IDX_W-1:0]        pos_idx;

  assign accept   = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);

  // Control broadcast to the cells: compare on accept, shift in the apply cycle.
  always_comb begin
    cell_ctl.op       = (state_q == ST_APPLY) ? apply_op : plst_pkg::CMD_HOLD;
    cell_ctl.idx      = apply_idx;
    cell_ctl.id       = (state_q == ST_IDLE) ? req_i.item_id : id_q;
    cell_ctl.match_en = accept;
    cell_ctl.count    = count_q;
  end

  // The chain of cells.
  for (genvar i = 0; i < plst_pkg::DEPTH; i++) begin : g_cell
    logic [plst_pkg::ID_BITS-1:0] left_data;
    logic [plst_pkg::ID_BITS-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = cell_ctl.id;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == plst_pkg::DEPTH - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    plst_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .index_i     (plst_pkg::IDX_W'(i)),
      .left_i      (left_data),
      .right_i     (right_data),
      .data_o      (cell_data[i]),
      .match_o     (match[i]),
      .tail_data_o (tail_data[i])
    );
  end

  plst_find u_find (
    .clk_i   (clk_i),
    .match_i (match),
    .hit_o   (hit),
    .index_o (hit_idx)
  );

  // Only the tail cell drives a nonzero value, so an OR gathers the last entry.
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < plst_pkg::DEPTH; i++) begin
      tail_or = tail_or | tail_data[i];
    end
  end

  // Request decode for the apply cycle.
  assign full    = (count_q == plst_pkg::CNT_W'(plst_pkg::DEPTH));
  assign empty   = (count_q == '0);
  assign ins_bad = (pos_q == '0) ||
                   (plst_pkg::CMP_W'(pos_q) >
                    plst_pkg::CMP_W'(count_q) + plst_pkg::CMP_W'(1));
  assign del_bad = (pos_q == '0) ||
                   (plst_pkg::CMP_W'(pos_q) > plst_pkg::CMP_W'(count_q));
  assign pos_idx = plst_pkg::IDX_W'(plst_pkg::CMP_W'(pos_q) - plst_pkg::CMP_W'(1));

  always_comb begin
    apply_op  = plst_pkg::CMD_HOLD;
    apply_idx = '0;
    status_d  = plst_pkg::ST_OK;
    found_d   = '0;
    count_d   = count_q;
    unique case (plst_pkg::plst_req_e'(req_q))
      plst_pkg::REQ_APPEND: begin
        if (full) begin
          status_d = plst_pkg::ST_FULL;
        end else begin
          apply_op  = plst_pkg::CMD_INSERT;
          apply_idx = plst_pkg::IDX_W'(count_q);
          count_d   = count_q + plst_pkg::CNT_W'(1);
        end
      end
      plst_pkg::REQ_INSERT: begin
        if (full) begin
          status_d = plst_pkg::ST_FULL;
        end else if (ins_bad) begin
          status_d = plst_pkg::ST_BADPOS;
        end else begin
          apply_op  = plst_pkg::CMD_INSERT;
          apply_idx = pos_idx;
          count_d   = count_q + plst_pkg::CNT_W'(1);
        end
      end
      plst_pkg::REQ_DEL_POS: begin
        if (empty) begin
          status_d = plst_pkg::ST_EMPTY;
        end else if (del_bad) begin
          status_d = plst_pkg::ST_BADPOS;
        end else begin
          apply_op  = plst_pkg::CMD_REMOVE;
          apply_idx = pos_idx;
          found_d   = plst_pkg::CNT_W'(pos_q);
          count_d   = count_q - plst_pkg::CNT_W'(1);
        end
      end
      plst_pkg::REQ_DEL_ID: begin
        if (empty) begin
          status_d = plst_pkg::ST_EMPTY;
        end else if (!hit) begin
          status_d = plst_pkg::ST_NOTFOUND;
        end else begin
          apply_op  = plst_pkg::CMD_REMOVE;
          apply_idx = hit_idx;
          found_d   = plst_pkg::CNT_W'(hit_idx) + plst_pkg::CNT_W'(1);
          count_d   = count_q - plst_pkg::CNT_W'(1);
        end
      end
      plst_pkg::REQ_SEARCH: begin
        if (!hit) begin
          status_d = plst_pkg::ST_NOTFOUND;
        end else begin
          found_d = plst_pkg::CNT_W'(hit_idx) + plst_pkg::CNT_W'(1);
        end
      end
      default: begin
        status_d = plst_pkg::ST_OK;
      end
    endcase
  end

  // Sequencer, count and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      req_q        <= '0;
      id_q         <= '0;
      pos_q        <= '0;
      status_q     <= plst_pkg::ST_OK;
      found_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_found_q  <= '0;
      rsp_count_q  <= '0;
      rsp_first_q  <= '0;
      rsp_last_q   <= '0;
    end else begin
      // The taken response is released unless the report stage refills it now.
      if (rsp_valid_q && rsp_o.ready && (state_q != ST_REPORT)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q   <= req_i.req_type;
            id_q    <= req_i.item_id;
            pos_q   <= req_i.position;
            state_q <= ST_FIND;
          end
        end
        ST_FIND: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          status_q <= status_d;
          found_q  <= found_d;
          count_q  <= count_d;
          state_q  <= ST_REPORT;
        end
        ST_REPORT: begin
          if (rsp_free) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_found_q  <= plst_pkg::POS_W'(found_q);
            rsp_count_q  <= plst_pkg::POS_W'(count_q);
            rsp_first_q  <= (count_q == '0) ? '0 : cell_data[0];
            rsp_last_q   <= tail_or;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.entry_count    = rsp_count_q;
  assign rsp_o.first_entry    = rsp_first_q;
  assign rsp_o.last_entry     = rsp_last_q;

  // An accepted request always moves straight into the search stage.
  a_accept_to_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_FIND))
    else $error("accepted request did not enter the search stage");

  // The count only changes as a result of the apply cycle.
  a_count_only_in_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_APPLY) |=> $stable(count_q))
    else $error("entry count changed outside the apply cycle");

  // One request moves the count by at most one entry.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=>
      (count_q == $past(count_q)) ||
      (count_q == $past(count_q) + plst_pkg::CNT_W'(1)) ||
      (count_q == $past(count_q) - plst_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= plst_pkg::CNT_W'(plst_pkg::DEPTH))
    else $error("entry count exceeds capacity");

endmodule
